/* rtl/assert_macros.svh */
// Assertion macros shared by the keypad scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, switched off while reset is asserted (active low).
`define KP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define KP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define KP_ASSERT(lbl, clk, rst_n, prop, msg)
`define KP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/kpscan_pkg.sv */
// Types and constants of the keypad scanner with number entry.
package kpscan_pkg;

    localparam int COL_W   = 4;
    localparam int ROW_W   = 4;
    localparam int VALUE_W = 17;
    localparam int EVENT_W = 2;
    localparam int DIGIT_W = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 17'h1FFFF;

    // floor(v / 10) as (v * DIV10_MUL) >> DIV10_SHIFT, exact for v below 2^18
    localparam logic [VALUE_W-1:0] DIV10_MUL   = 17'd104858;
    localparam int                 DIV10_SHIFT = 20;

    // Key codes after table lookup; digits are their own value
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_BACK      = 4'd10;
    localparam logic [3:0] KEY_ENTER     = 4'd11;
    localparam logic [3:0] KEY_ESC       = 4'd12;
    localparam logic [3:0] KEY_NONE      = 4'd13;

    // Indexed by {row, column}
    localparam logic [3:0] KEY_CODES [16] = '{
        4'd1,     4'd2, 4'd3,      KEY_NONE,
        4'd4,     4'd5, 4'd6,      KEY_NONE,
        4'd7,     4'd8, 4'd9,      KEY_NONE,
        KEY_BACK, 4'd0, KEY_ENTER, KEY_ESC
    };

    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DIGIT  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_REMOVE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_FINISH = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PROBE   = 4'b0010,
        PH_COLREAD = 4'b0100,
        PH_RELEASE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [COL_W-1:0] column_lines;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]   row_drive;
        logic [EVENT_W-1:0] entry_event;
        logic [DIGIT_W-1:0] event_digit;
        logic [VALUE_W-1:0] entry_value;
        logic               skipped;
    } t_res_item;

    typedef struct packed {
        logic [VALUE_W-1:0] default_value;
    } t_cfg_item;

    // Row pattern with the given row low and every other row high
    function automatic logic [ROW_W-1:0] probe_pattern(input logic [1:0] row);
        probe_pattern = ~(4'b0001 << row);
    endfunction

endpackage

/* rtl/kpscan_stream_if.sv */
// Valid/ready channel carrying one payload of a chosen type.
interface kpscan_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/keypad_scan_number_entry_unit.sv */
// Keypad matrix scanner that turns key releases into decimal number entry.
//
//  channel | dir | payload                                         | transaction
//  i_in    | in  | column_lines                                    | valid & ready
//  o_res   | out | row_drive, entry_event, event_digit, value, skip | valid & ready
//  i_cfg   | in  | default_value                                   | valid & ready
//
// One sample per cycle: the state update and the result both sit between the
// scan state registers and the output register; the only arithmetic is a
// constant multiply by ten and a reciprocal multiply for divide by ten.
// A two-entry output stage (output register plus skid) keeps i_in ready while
// one result waits; i_in stalls only when both entries are full.
// Synchronous active-low reset returns the scanner to idle with no digits held
// and default_value zero; the configuration port is always ready.
module keypad_scan_number_entry_unit
    import kpscan_pkg::*;
#(
    parameter int MAX_DIGITS  = 5,
    parameter int MATRIX_SIZE = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    kpscan_stream_if.sink          i_in,
    kpscan_stream_if.source        o_res,
    kpscan_stream_if.sink          i_cfg
);

    localparam int               CNT_W    = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DIGITS);
    localparam logic [COL_W-1:0] COL_MASK = COL_W'((1 << MATRIX_SIZE) - 1);
    localparam logic [2:0]       ROW_LAST = 3'(MATRIX_SIZE);

    t_phase             r_phase,     n_phase;
    logic [1:0]         r_probe,     n_probe;
    logic               r_found_ok,  n_found_ok;
    logic [1:0]         r_found_row, n_found_row;
    logic [3:0]         r_pend_key,  n_pend_key;
    logic               r_pend_ok,   n_pend_ok;
    logic [VALUE_W-1:0] r_acc,       n_acc;
    logic [CNT_W-1:0]   r_count,     n_count;
    logic [VALUE_W-1:0] r_default;

    t_res_item          n_res;
    t_res_item          r_out;
    t_res_item          r_skid;
    logic               r_out_valid;
    logic               r_skid_valid;

    logic               w_accept;
    logic               w_out_fire;
    logic [COL_W-1:0]   w_cols;
    logic               w_any_low;
    logic               w_col_ok;
    logic [1:0]         w_col_idx;
    logic [3:0]         w_code;
    logic [20:0]        w_mul10;
    logic [VALUE_W-1:0] w_acc_next;
    logic [33:0]        w_div_prod;
    logic [VALUE_W-1:0] w_div10;

    assign i_in.ready  = !r_skid_valid;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_fire = r_out_valid && o_res.ready;

    assign w_cols    = i_in.data.column_lines;
    assign w_any_low = (w_cols & COL_MASK) != COL_MASK;

    // first low column wins
    always_comb begin
        w_col_ok  = 1'b0;
        w_col_idx = 2'd0;
        for (int c = MATRIX_SIZE - 1; c >= 0; c--) begin
            if (!w_cols[c]) begin
                w_col_ok  = 1'b1;
                w_col_idx = 2'(c);
            end
        end
    end

    assign w_code     = KEY_CODES[r_pend_key];
    assign w_mul10    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 21'(w_code);
    assign w_acc_next = (w_mul10 > 21'(VALUE_MAX)) ? VALUE_MAX : w_mul10[VALUE_W-1:0];
    assign w_div_prod = {17'b0, r_acc} * {17'b0, DIV10_MUL};
    assign w_div10    = {3'b0, w_div_prod[33:DIV10_SHIFT]};

    always_comb begin
        n_phase     = r_phase;
        n_probe     = r_probe;
        n_found_ok  = r_found_ok;
        n_found_row = r_found_row;
        n_pend_key  = r_pend_key;
        n_pend_ok   = r_pend_ok;
        n_acc       = r_acc;
        n_count     = r_count;
        n_res       = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (w_any_low) begin
                    n_probe           = 2'd0;
                    n_found_ok        = 1'b0;
                    n_phase           = PH_PROBE;
                    n_res.row_drive   = probe_pattern(2'd0);
                end
            end
            PH_PROBE: begin
                if (w_any_low) begin
                    n_found_ok  = 1'b1;
                    n_found_row = r_probe;
                    n_phase     = PH_COLREAD;
                end else if (({1'b0, r_probe} + 3'd1) >= ROW_LAST) begin
                    n_found_ok = 1'b0;
                    n_phase    = PH_COLREAD;
                end else begin
                    n_probe         = r_probe + 2'd1;
                    n_res.row_drive = probe_pattern(r_probe + 2'd1);
                end
            end
            PH_COLREAD: begin
                n_pend_ok = 1'b0;
                if (r_found_ok && w_col_ok) begin
                    n_pend_key = {r_found_row, w_col_idx};
                    n_pend_ok  = 1'b1;
                end
                n_phase = PH_RELEASE;
            end
            PH_RELEASE: begin
                if (!w_any_low) begin
                    if (r_pend_ok) begin
                        priority if (w_code <= KEY_DIGIT_MAX) begin
                            if (r_count < CNT_MAX) begin
                                n_acc             = w_acc_next;
                                n_count           = r_count + CNT_W'(1);
                                n_res.entry_event = EV_DIGIT;
                                n_res.event_digit = w_code;
                            end
                        end else if (w_code == KEY_BACK) begin
                            if (r_count != '0) begin
                                n_acc             = w_div10;
                                n_count           = r_count - CNT_W'(1);
                                n_res.entry_event = EV_REMOVE;
                            end
                        end else if (w_code == KEY_ENTER || w_code == KEY_ESC) begin
                            n_res.entry_event = EV_FINISH;
                            if (w_code == KEY_ENTER && r_count != '0) begin
                                n_res.entry_value = r_acc;
                            end else begin
                                n_res.entry_value = r_default;
                                n_res.skipped     = 1'b1;
                            end
                            n_acc   = '0;
                            n_count = '0;
                        end else begin
                            // keys a, b and c: drop
                        end
                    end
                    n_pend_ok = 1'b0;
                    n_phase   = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_probe     <= 2'd0;
            r_found_ok  <= 1'b0;
            r_found_row <= 2'd0;
            r_pend_key  <= 4'd0;
            r_pend_ok   <= 1'b0;
            r_acc       <= '0;
            r_count     <= '0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_probe     <= n_probe;
            r_found_ok  <= n_found_ok;
            r_found_row <= n_found_row;
            r_pend_key  <= n_pend_key;
            r_pend_ok   <= n_pend_ok;
            r_acc       <= n_acc;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_default <= i_cfg.data.default_value;
        end
    end

    // output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= n_res;
            end
        end else if (w_accept) begin
            r_skid <= n_res;
        end
    end

`include "assert_macros.svh"

    `KP_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid holds a result while the output register is empty")
    `KP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_MAX, "digit count beyond limit")
    `KP_ASSERT(a_empty_is_zero, i_clk, i_rst_n, (r_count == '0) |-> (r_acc == '0), "value held with no digits")
    `KP_ASSERT(a_full_stalls, i_clk, i_rst_n, (r_out_valid && r_skid_valid && !o_res.ready) |=> r_skid_valid, "stalled skid entry lost")

endmodule
